>>> hw/rtl/cpc_pkg.sv
// shared types and constants for the chroma polar converter
// word structs, pipeline control struct, cordic arctangent table
// no dependencies
package cpc_pkg;

    // default number of fractional bits and cordic steps
    localparam int FRAC_BITS_DEF = 16;

    // integer bits above the fraction for coordinates and for angles
    localparam int CORD_INT = 13;
    localparam int ANG_INT  = 3;

    // bit-by-bit square root of a 17 bit value gives 9 result bits
    localparam int ROOT_BITS = 9;
    localparam int ROOT_SW   = 17;

    // inverse cordic gain, 32 fractional bits
    localparam logic [31:0] KINV32 = 32'd2608131496;

    // atan(2^-i) in units of pi/2^31
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [7:0] first_chroma;
        logic [7:0] second_chroma;
        logic       last_pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] first_result;
        logic [7:0] second_result;
        logic       last_pixel_out;
    } t_out_word;

    // control carried alongside each word through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic inv;   // polar to cartesian
        logic hold;  // vector on the v axis, angle already known
        logic neg;   // rotation folded by pi, negate result
    } t_ctrl;

    typedef struct packed {
        logic [ROOT_SW-1:0]   s;
        logic [ROOT_BITS-1:0] r;
    } t_root;

endpackage

>>> hw/rtl/cpc_front.sv
// input conditioning: two register stages that build the cordic start vector
// and the square root operand from one chroma word
// depends on cpc_pkg
module cpc_front import cpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_inv,
    input  t_in_word                          i_in,
    output t_ctrl                             o_ctrl,
    output logic signed [FRAC_BITS+CORD_INT-1:0] o_x,
    output logic signed [FRAC_BITS+CORD_INT-1:0] o_y,
    output logic signed [FRAC_BITS+ANG_INT-1:0]  o_z,
    output t_root                             o_root
);

    localparam int W  = FRAC_BITS + CORD_INT;
    localparam int ZW = FRAC_BITS + ANG_INT;
    localparam int PW = FRAC_BITS + 17;
    localparam logic signed [ZW-1:0] ONE  = ZW'(1) <<< FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] KINV = FRAC_BITS'(KINV32 >> (32 - FRAC_BITS));

    // stage 0
    logic signed [8:0]    w_u, w_bm;
    logic signed [15:0]   w_d;
    logic signed [17:0]   w_u18, w_bm18, w_sq_a, w_sq_b;
    logic signed [ZW-1:0] w_z0, n0_z;
    logic                 n0_neg;

    t_ctrl                r0_ctrl;
    logic signed [8:0]    r0_u, r0_v;
    logic signed [15:0]   r0_d;
    logic [14:0]          r0_uu, r0_vv;
    logic signed [ZW-1:0] r0_z;
    logic                 r0_neg;

    // stage 1
    logic signed [PW-1:0] w_prod, w_prod_sh;
    logic signed [W-1:0]  w_x4, w_y3;
    logic [15:0]          w_sum;
    logic signed [W-1:0]  n1_x, n1_y;
    logic signed [ZW-1:0] n1_z;
    t_ctrl                n1_ctrl;

    t_ctrl                r1_ctrl;
    logic signed [W-1:0]  r1_x, r1_y;
    logic signed [ZW-1:0] r1_z;
    t_root                r1_root;

    assign w_u    = $signed({1'b0, i_in.first_chroma}) - 9'sd128;
    assign w_bm   = $signed({1'b0, i_in.second_chroma}) - 9'sd80;
    assign w_d    = 16'(w_bm) * 16'sd181;
    assign w_u18  = 18'(w_u);
    // v is second - 128, reuse the 80 offset
    assign w_bm18 = 18'(w_bm) - 18'sd48;
    assign w_sq_a = w_u18 * w_u18;
    assign w_sq_b = w_bm18 * w_bm18;
    assign w_z0   = ZW'(w_u) <<< (FRAC_BITS - 7);

    // fold the rotation angle into -pi/2..pi/2
    always_comb begin
        n0_z   = w_z0;
        n0_neg = 1'b0;
        if (w_z0 > HALF) begin
            n0_z   = w_z0 - ONE;
            n0_neg = 1'b1;
        end else if (w_z0 < -HALF) begin
            n0_z   = w_z0 + ONE;
            n0_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctrl <= '0;
        end else begin
            r0_ctrl.valid <= i_valid;
            r0_ctrl.last  <= i_in.last_pixel_in;
            r0_ctrl.inv   <= i_inv;
            r0_ctrl.hold  <= 1'b0;
            r0_ctrl.neg   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_u   <= w_u;
        r0_v   <= 9'(w_bm18);
        r0_d   <= w_d;
        r0_uu  <= 15'(w_sq_a);
        r0_vv  <= 15'(w_sq_b);
        r0_z   <= n0_z;
        r0_neg <= n0_neg;
    end

    // radius times inverse gain, then divide by 128
    assign w_prod    = PW'(r0_d) * $signed(PW'({1'b0, KINV}));
    assign w_prod_sh = w_prod >>> 7;

    assign w_x4  = W'(r0_v) <<< (FRAC_BITS + 2);
    assign w_y3  = (W'(r0_u) <<< (FRAC_BITS + 1)) + (W'(r0_u) <<< FRAC_BITS);
    assign w_sum = {1'b0, r0_uu} + {1'b0, r0_vv};

    always_comb begin
        n1_ctrl      = r0_ctrl;
        n1_ctrl.hold = 1'b0;
        n1_ctrl.neg  = 1'b0;
        n1_x         = w_x4;
        n1_y         = w_y3;
        n1_z         = '0;
        if (r0_ctrl.inv) begin
            n1_x        = W'(w_prod_sh);
            n1_y        = '0;
            n1_z        = r0_z;
            n1_ctrl.neg = r0_neg;
        end else if (r0_u == 9'sd0) begin
            // on the v axis: angle is 0 or pi
            n1_ctrl.hold = 1'b1;
            n1_z         = r0_v[8] ? ONE : '0;
        end else if (r0_v[8]) begin
            n1_x = -w_x4;
            n1_y = -w_y3;
            n1_z = r0_u[8] ? -ONE : ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
        end else begin
            r1_ctrl <= n1_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x      <= n1_x;
        r1_y      <= n1_y;
        r1_z      <= n1_z;
        r1_root.s <= {w_sum, 1'b0};
        r1_root.r <= '0;
    end

    assign o_ctrl = r1_ctrl;
    assign o_x    = r1_x;
    assign o_y    = r1_y;
    assign o_z    = r1_z;
    assign o_root = r1_root;

endmodule

>>> hw/rtl/cpc_cell.sv
// one cordic micro-rotation and, in the first cells, one square root bit
// the step number is fixed per cell, the shift and angle are constants
// depends on cpc_pkg
module cpc_cell import cpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int STEP      = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_ctrl                                i_ctrl,
    input  logic signed [FRAC_BITS+CORD_INT-1:0] i_x,
    input  logic signed [FRAC_BITS+CORD_INT-1:0] i_y,
    input  logic signed [FRAC_BITS+ANG_INT-1:0]  i_z,
    input  t_root                                i_root,
    output t_ctrl                                o_ctrl,
    output logic signed [FRAC_BITS+CORD_INT-1:0] o_x,
    output logic signed [FRAC_BITS+CORD_INT-1:0] o_y,
    output logic signed [FRAC_BITS+ANG_INT-1:0]  o_z,
    output t_root                                o_root
);

    localparam int W  = FRAC_BITS + CORD_INT;
    localparam int ZW = FRAC_BITS + ANG_INT;
    localparam logic [31:0]   ANG32 = ATAN_TAB[STEP];
    localparam logic [ZW-1:0] ANG   = ZW'(ANG32 >> (31 - FRAC_BITS));

    logic signed [W-1:0]  w_dx, w_dy, n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 w_pos;
    t_root                n_root;

    t_ctrl                r_ctrl;
    logic signed [W-1:0]  r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_root                r_root;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;
    // vectoring drives y to zero, rotation drives z to zero
    assign w_pos = i_ctrl.inv ? !i_z[ZW-1] : (i_y[W-1] || (i_y == '0));

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (!i_ctrl.hold) begin
            if (w_pos) begin
                n_x = i_x - w_dx;
                n_y = i_y + w_dy;
                n_z = i_z - $signed(ANG);
            end else begin
                n_x = i_x + w_dx;
                n_y = i_y - w_dy;
                n_z = i_z + $signed(ANG);
            end
        end
    end

    generate
        if (STEP < ROOT_BITS) begin : g_root
            localparam logic [ROOT_BITS-1:0] RBIT = ROOT_BITS'(256 >> STEP);
            logic [ROOT_BITS-1:0] w_try;
            logic [17:0]          w_try18, w_sq;
            assign w_try   = i_root.r | RBIT;
            assign w_try18 = 18'(w_try);
            assign w_sq    = w_try18 * w_try18;
            always_comb begin
                n_root = i_root;
                if (w_sq <= 18'(i_root.s)) begin
                    n_root.r = w_try;
                end
            end
        end else begin : g_pass
            assign n_root = i_root;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_root <= n_root;
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_root = r_root;

endmodule

>>> hw/rtl/cpc_back.sv
// output stage: turns the final cordic vector, angle and root into bytes
// and registers the result word with its strobe
// depends on cpc_pkg
module cpc_back import cpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_ctrl                                i_ctrl,
    input  logic signed [FRAC_BITS+CORD_INT-1:0] i_x,
    input  logic signed [FRAC_BITS+CORD_INT-1:0] i_y,
    input  logic signed [FRAC_BITS+ANG_INT-1:0]  i_z,
    input  t_root                                i_root,
    output logic                                 o_strobe,
    output t_out_word                            o_out
);

    localparam int W  = FRAC_BITS + CORD_INT;
    localparam int ZW = FRAC_BITS + ANG_INT;
    localparam logic signed [ZW:0] ONE = (ZW + 1)'(1) <<< FRAC_BITS;

    logic signed [ZW:0]        w_t;
    logic [8:0]                w_a9;
    logic signed [W-1:0]       w_xn, w_yn;
    logic signed [CORD_INT:0]  w_qx, w_qy;
    t_out_word                 n_out;

    logic                      r_strobe;
    t_out_word                 r_out;

    function automatic logic [7:0] clamp_byte(input logic signed [CORD_INT:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // angle plus pi, negative taken as zero
    assign w_t  = (ZW + 1)'(i_z) + ONE;
    assign w_a9 = w_t[ZW] ? 9'd0 : w_t[FRAC_BITS+1:FRAC_BITS-7];

    // integer part keeps its sign, so negative coordinates floor correctly
    assign w_xn = i_ctrl.neg ? -i_x : i_x;
    assign w_yn = i_ctrl.neg ? -i_y : i_y;
    assign w_qx = (CORD_INT + 1)'($signed(w_xn[W-1:FRAC_BITS])) + (CORD_INT + 1)'(128);
    assign w_qy = (CORD_INT + 1)'($signed(w_yn[W-1:FRAC_BITS])) + (CORD_INT + 1)'(128);

    always_comb begin
        n_out.last_pixel_out = i_ctrl.last;
        if (i_ctrl.inv) begin
            n_out.first_result  = clamp_byte(w_qy);
            n_out.second_result = clamp_byte(w_qx);
        end else begin
            n_out.first_result  = w_a9[8] ? 8'd255 : w_a9[7:0];
            n_out.second_result = 8'd80 + 8'(i_root.r[ROOT_BITS-1:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

>>> hw/rtl/chroma_polar_converter.sv
// top level of the chroma polar converter
// front stage, a row of cordic cells and the output stage
// depends on cpc_pkg, cpc_front, cpc_cell, cpc_back
//
// usage
//   a pixel word (first_chroma, second_chroma, last_pixel_in) is taken at
//   every rising edge with start high; busy is held low, so one word may
//   enter on every clock and many words are in flight at once
//   direction (i_cfg_we / i_cfg_wdata) picks cartesian to polar (0) or polar
//   to cartesian (1); write it only while no word is in flight
//   each word leaves on o_out for exactly one cycle with o_strobe high,
//   after two front stages, one cordic cell per step and one output stage;
//   the receiver cannot stall, results are simply presented in order
//   throughput is one word per clock, set by the unrolled row of cells
//   the square root for the forward magnitude runs one bit per cell in the
//   first nine cells, next to the cordic steps
//   reset clears direction to forward and drops every word in flight; no
//   strobe appears until new words come in
module chroma_polar_converter import cpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_strobe,
    output t_out_word o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    localparam int W  = FRAC_BITS + CORD_INT;
    localparam int ZW = FRAC_BITS + ANG_INT;

    // direction register
    logic r_direction;

    // chain taps: index 0 is the front output, index FRAC_BITS the last cell
    t_ctrl                w_ctrl [FRAC_BITS+1];
    logic signed [W-1:0]  w_x    [FRAC_BITS+1];
    logic signed [W-1:0]  w_y    [FRAC_BITS+1];
    logic signed [ZW-1:0] w_z    [FRAC_BITS+1];
    t_root                w_root [FRAC_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_wdata;
        end
    end

    // fully pipelined, never refuses a word
    assign busy = 1'b0;

    cpc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_inv   (r_direction),
        .i_in    (i_in),
        .o_ctrl  (w_ctrl[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_root  (w_root[0])
    );

    // one cell per cordic step, each hands its word on every clock
    generate
        for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
            cpc_cell #(
                .FRAC_BITS (FRAC_BITS),
                .STEP      (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl[k]),
                .i_x     (w_x[k]),
                .i_y     (w_y[k]),
                .i_z     (w_z[k]),
                .i_root  (w_root[k]),
                .o_ctrl  (w_ctrl[k+1]),
                .o_x     (w_x[k+1]),
                .o_y     (w_y[k+1]),
                .o_z     (w_z[k+1]),
                .o_root  (w_root[k+1])
            );
        end
    endgenerate

    cpc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl[FRAC_BITS]),
        .i_x      (w_x[FRAC_BITS]),
        .i_y      (w_y[FRAC_BITS]),
        .i_z      (w_z[FRAC_BITS]),
        .i_root   (w_root[FRAC_BITS]),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

>>> tb/tb_chroma_polar_converter.sv
// self-checking testbench for chroma_polar_converter, both conversion directions
// predicts every pixel word with a cordic model of its own and compares each strobed word
// depends on cpc_pkg and the chroma_polar_converter rtl
module tb_chroma_polar_converter import cpc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    // two front stages, one cell per cordic step, one output stage
    localparam int LATENCY = FRAC_BITS + 3;
    // longest quiet stretch is the final drain and wait at the end of the run, far below this
    localparam int STALL_LIMIT = 1000;

    // direction register codes
    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_in;
    logic      o_strobe;
    t_out_word o_out;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    // words predicted at acceptance, oldest first
    t_out_word predicted_words[$];
    // direction as the block should currently hold it
    logic      model_dir;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    chroma_polar_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // atan(2^-i) in units of pi/2^FRAC_BITS, truncated from the 31 bit table
    function automatic longint atan_step(int i);
        return longint'(ATAN_TAB[i % 32] >> (31 - FRAC_BITS));
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // one pixel word through the converter; >>> on longint floors, as the block's shifts do
    function automatic t_out_word convert_chroma(logic dir, t_in_word w);
        longint    one, half, a, b, u, v, x, y, ang, dx, dy, sq, root, trial, kinv;
        logic      neg, turn_up;
        t_out_word r;
        one = longint'(1) << FRAC_BITS;
        half = one >>> 1;
        a = longint'(w.first_chroma);
        b = longint'(w.second_chroma);
        if (dir == DIR_FORWARD) begin
            // vectoring on (4v, 3u), i.e. atan2(0.75u, v)
            u = a - 128;
            v = b - 128;
            x = 4 * v * one;
            y = 3 * u * one;
            ang = 0;
            if (y == 0) begin
                // on the v axis the angle is exact: 0 or pi
                ang = (x < 0) ? one : 0;
            end else begin
                // left half plane: fold by pi first
                if (x < 0) begin
                    ang = (y > 0) ? one : -one;
                    x = -x;
                    y = -y;
                end
                for (int i = 0; i < FRAC_BITS; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    turn_up = (y > 0);
                    if (turn_up) begin
                        x += dx;
                        y -= dy;
                        ang += atan_step(i);
                    end else begin
                        x -= dx;
                        y += dy;
                        ang -= atan_step(i);
                    end
                end
            end
            ang = ang + one;
            if (ang < 0) ang = 0;
            r.first_result = clamp_byte(ang >>> (FRAC_BITS - 7));
            // exact integer square root of 2(u^2+v^2)
            sq = 2 * (u * u + v * v);
            root = 0;
            for (trial = 256; trial > 0; trial = trial >>> 1) begin
                if ((root + trial) * (root + trial) <= sq) root += trial;
            end
            r.second_result = clamp_byte(80 + (root >>> 1));
        end else begin
            // rotation of (l*Kinv, 0) by t = pi*(a/128 - 1)
            ang = (a - 128) * (longint'(1) << (FRAC_BITS - 7));
            kinv = longint'(KINV32 >> (32 - FRAC_BITS));
            x = ((b - 80) * 181 * kinv) >>> 7;
            y = 0;
            neg = 1'b0;
            if (ang > half) begin
                ang -= one;
                neg = 1'b1;
            end else if (ang < -half) begin
                ang += one;
                neg = 1'b1;
            end
            for (int i = 0; i < FRAC_BITS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                turn_up = (ang >= 0);
                if (turn_up) begin
                    x -= dx;
                    y += dy;
                    ang -= atan_step(i);
                end else begin
                    x += dx;
                    y -= dy;
                    ang += atan_step(i);
                end
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            r.first_result = clamp_byte((y + 128 * one) >>> FRAC_BITS);
            r.second_result = clamp_byte((x + 128 * one) >>> FRAC_BITS);
        end
        r.last_pixel_out = w.last_pixel_in;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: checks strobed words, predicts accepted ones, watchdog
    // all reads here see the values from before the edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        logic      took;
        if (!i_rst_n) begin
            model_dir = DIR_FORWARD;
            quiet_cycles = 0;
        end else begin
            took = start && !busy;
            if (o_strobe) begin
                if (predicted_words.size() == 0) begin
                    $display("%0t: word with none expected, actual %h", $time, o_out);
                    mismatches++;
                end else begin
                    want = predicted_words.pop_front();
                    if (o_out.first_result !== want.first_result) begin
                        $display("%0t: first_result expected %0d actual %0d",
                                 $time, want.first_result, o_out.first_result);
                        mismatches++;
                    end
                    if (o_out.second_result !== want.second_result) begin
                        $display("%0t: second_result expected %0d actual %0d",
                                 $time, want.second_result, o_out.second_result);
                        mismatches++;
                    end
                    if (o_out.last_pixel_out !== want.last_pixel_out) begin
                        $display("%0t: last_pixel_out expected %0b actual %0b",
                                 $time, want.last_pixel_out, o_out.last_pixel_out);
                        mismatches++;
                    end
                end
            end
            // predicted with the direction in force when the word is taken
            if (took) predicted_words.push_back(convert_chroma(model_dir, i_in));
            if (i_cfg_we) model_dir = i_cfg_wdata;
            quiet_cycles = (took || o_strobe) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one word and hold it until the block takes it; busy is looked at
    // mid-cycle so the decision matches the edge that follows
    task automatic send_pixel(logic [7:0] first, logic [7:0] second, logic last);
        logic taken;
        start <= 1'b1;
        i_in <= t_in_word'{first_chroma: first, second_chroma: second, last_pixel_in: last};
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // sender gap of random length, start held low
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge i_clk);
    endtask

    // stop offering and wait for every predicted word to come out; the wait
    // starts after an edge so the last accepted word is already in the queue
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // direction is only changed with nothing in flight
    task automatic set_direction(logic dir);
        drain_pipeline();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= dir;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random pixels; stretches with and without sender gaps alternate
    task automatic run_random(int count, bit allow_idle);
        logic [7:0] first, second;
        logic       last;
        bit         idle_on;
        int         stretch;
        idle_on = 1'b1;
        stretch = $urandom_range(10, 60);
        for (int k = 0; k < count; k++) begin
            if (stretch == 0) begin
                idle_on = !idle_on;
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            if (allow_idle && idle_on && $urandom_range(0, 2) == 0) idle_burst();
            first = $urandom_range(0, 255);
            second = $urandom_range(0, 255);
            // now and then sit on an axis or at the origin of the chroma plane
            if ($urandom_range(0, 9) == 0) first = 8'd128;
            if ($urandom_range(0, 9) == 0) second = 8'd128;
            last = ($urandom_range(0, 15) == 0);
            send_pixel(first, second, last);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // cartesian to polar: origin, both v half axes, corners, edge midpoints
    task automatic test_forward_corners();
        set_direction(DIR_FORWARD);
        send_pixel(8'd128, 8'd128, 1'b0);  // zero vector, angle byte 128
        send_pixel(8'd128, 8'd0,   1'b0);  // negative v axis, angle clamps to 255
        send_pixel(8'd128, 8'd1,   1'b0);
        send_pixel(8'd128, 8'd255, 1'b1);  // positive v axis
        send_pixel(8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd128, 1'b0);
        send_pixel(8'd255, 8'd128, 1'b1);
        send_pixel(8'd129, 8'd127, 1'b0);
    endtask

    // polar to cartesian: angle extremes, the quarter-turn fold boundary,
    // zero and negative radius, largest radius
    task automatic test_inverse_corners();
        set_direction(DIR_INVERSE);
        send_pixel(8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd255, 1'b0);
        send_pixel(8'd64,  8'd200, 1'b0);  // exactly -pi/2, no fold
        send_pixel(8'd63,  8'd200, 1'b0);  // just past -pi/2, folded
        send_pixel(8'd192, 8'd200, 1'b0);  // exactly +pi/2
        send_pixel(8'd193, 8'd200, 1'b1);  // just past +pi/2
        send_pixel(8'd128, 8'd80,  1'b0);  // zero radius
        send_pixel(8'd100, 8'd79,  1'b0);  // magnitude below 80, negative radius
        send_pixel(8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd0,   1'b1);
        send_pixel(8'd170, 8'd85,  1'b0);
        send_pixel(8'd128, 8'd0,   1'b1);
    endtask

    task automatic test_forward_random();
        set_direction(DIR_FORWARD);
        run_random(150, 1'b1);
    endtask

    task automatic test_inverse_random();
        set_direction(DIR_INVERSE);
        run_random(150, 1'b1);
    endtask

    // direction flipped between phases, each phase drained first
    task automatic test_direction_switching();
        for (int phase = 0; phase < 6; phase++) begin
            set_direction((phase % 2 == 0) ? DIR_FORWARD : DIR_INVERSE);
            run_random(30, 1'b1);
        end
    endtask

    // one word on every clock, no gaps, to close the run
    task automatic test_full_rate();
        set_direction($urandom_range(0, 1) ? DIR_INVERSE : DIR_FORWARD);
        run_random(80, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        start <= 1'b0;
        i_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_forward_corners();
        test_inverse_corners();
        test_forward_random();
        test_inverse_random();
        test_direction_switching();
        test_full_rate();

        // let the last words out, then a little more for any stray strobe
        drain_pipeline();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> chroma_polar_converter.f
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_front.sv
hw/rtl/cpc_cell.sv
hw/rtl/cpc_back.sv
hw/rtl/chroma_polar_converter.sv
tb/tb_chroma_polar_converter.sv
